### rtl/wch_pkg.sv
package wch_pkg;

   localparam int BINS_PER_CHANNEL_DEF = 16;
   localparam int COUNT_WIDTH_DEF      = 40;
   localparam int CHANNEL_RANGE        = 256;

   localparam int CHAN_W  = 8;
   localparam int SHARE_W = 17;
   localparam int DIV_STEPS = SHARE_W;

   localparam logic [SHARE_W-1:0] ONE_Q16 = SHARE_W'(65536);

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ACCUM = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [CHAN_W-1:0]  chan_a;
      logic [CHAN_W-1:0]  chan_b;
      logic [CHAN_W-1:0]  chan_c;
      logic [SHARE_W-1:0] pixel_weight;
   } req_type;

   typedef struct packed {
      logic [SHARE_W-1:0] bin_share;
      logic               total_zero;
   } rsp_type;

endpackage

### rtl/weighted_color_histogram.sv
// Weighted 3-channel color histogram, BINS_PER_CHANNEL^3 bins of COUNT_WIDTH-bit
// Q24.16 counts (default width) held in a single-port-write, registered-read memory.
// Command beats: start with req_data, taken when busy is low. Opcodes:
//   clear      - zeroes every bin and the total; busy until the pass ends.
//   accumulate - adds the pixel weight capped at 1.0 (or 1.0 when use_weights is
//                0) to the pixel's bin and to the total, both saturating; steps
//                per pixel: accept, memory read, read-modify-write.
//   query      - returns floor(bin * 65536 / total) on rsp_data with a one-cycle
//                rsp_strobe; total_zero is set and the share is 0 on an empty
//                histogram. The result is registered from S_Q_LD when empty,
//                else from the last S_Q_DIV step: one restoring divide step per cycle
//                over 17 quotient bits in a shared compare/subtract unit.
//   opcode 3   - ignored.
// csr_we/csr_wdata write use_weights (reset 1); write only while idle.
// Reset starts a clearing pass over all NUM_BINS bins (4096 by default) of
// the bin memory; busy is high during it. The receiver cannot stall: each
// result is valid for exactly the one cycle that rsp_strobe is high.
module weighted_color_histogram #(
   parameter int BINS_PER_CHANNEL = wch_pkg::BINS_PER_CHANNEL_DEF,
   parameter int COUNT_WIDTH      = wch_pkg::COUNT_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  wch_pkg::req_type req_data,
   input  logic             csr_we,
   input  logic             csr_wdata,
   output logic             rsp_strobe,
   output wch_pkg::rsp_type rsp_data
);

   localparam int NUM_BINS      = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
   localparam int IDX_W         = $clog2(NUM_BINS);
   localparam int BIN_WIDTH_RAW = wch_pkg::CHANNEL_RANGE / BINS_PER_CHANNEL;
   localparam int BIN_WIDTH     = (BIN_WIDTH_RAW == 0) ? 1 : BIN_WIDTH_RAW;
   localparam int BIN_RECIP     = (65536 + BIN_WIDTH - 1) / BIN_WIDTH;
   localparam int CNT_W         = $clog2(wch_pkg::DIV_STEPS);
   localparam int CW            = COUNT_WIDTH;
   localparam int SW            = wch_pkg::SHARE_W;
   localparam int CH            = wch_pkg::CHAN_W;

   localparam logic [IDX_W-1:0] LAST_BIN  = IDX_W'(NUM_BINS - 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(wch_pkg::DIV_STEPS - 1);
   localparam logic [CH-1:0]    TOP_BIN   = CH'(BINS_PER_CHANNEL - 1);
   localparam logic [CW-1:0]    COUNT_MAX = {CW{1'b1}};

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ACC_RD,
      S_ACC_UPD,
      S_Q_RD,
      S_Q_LD,
      S_Q_DIV
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SW-1:0]    weight_ff, weight_in;
   logic [CW-1:0]    total_ff, total_in;
   logic [CW:0]      rem_ff, rem_in;
   logic [SW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             use_weights_ff, use_weights_in;
   logic             strobe_ff, strobe_in;
   wch_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0]    mem [NUM_BINS];
   logic [CW-1:0]    rdata_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [CW-1:0]    mem_wdata;

   logic [CH-1:0]    bin_a, bin_b, bin_c;
   logic [IDX_W-1:0] flat_idx;
   logic [SW-1:0]    weight_eff;
   logic [CW:0]      bin_sum, tot_sum;
   logic [CW-1:0]    bin_sat, tot_sat, num_clip;
   logic [CW:0]      trial;
   logic             ge;

   // v / BIN_WIDTH as a reciprocal multiply, exact for 8-bit v
   function automatic logic [CH-1:0] chan_bin(input logic [CH-1:0] v);
      logic [CH+16:0] prod;
      logic [CH-1:0]  b;
      prod = (CH+17)'(v) * (CH+17)'(BIN_RECIP);
      b    = prod[CH+15:16];
      return (b > TOP_BIN) ? TOP_BIN : b;
   endfunction

   always_comb begin
      bin_a    = chan_bin(req_data.chan_a);
      bin_b    = chan_bin(req_data.chan_b);
      bin_c    = chan_bin(req_data.chan_c);
      flat_idx = IDX_W'((IDX_W'(bin_a) * IDX_W'(BINS_PER_CHANNEL) + IDX_W'(bin_b))
                        * IDX_W'(BINS_PER_CHANNEL) + IDX_W'(bin_c));
      if (use_weights_ff) begin
         weight_eff = (req_data.pixel_weight > wch_pkg::ONE_Q16) ? wch_pkg::ONE_Q16
                                                               : req_data.pixel_weight;
      end else begin
         weight_eff = wch_pkg::ONE_Q16;
      end
   end

   // saturating count update and one restoring divide step
   always_comb begin
      bin_sum  = {1'b0, rdata_ff} + (CW+1)'(weight_ff);
      tot_sum  = {1'b0, total_ff} + (CW+1)'(weight_ff);
      bin_sat  = bin_sum[CW] ? COUNT_MAX : bin_sum[CW-1:0];
      tot_sat  = tot_sum[CW] ? COUNT_MAX : tot_sum[CW-1:0];
      num_clip = (rdata_ff > total_ff) ? total_ff : rdata_ff;
      trial    = (cnt_ff == '0) ? rem_ff : {rem_ff[CW-1:0], 1'b0};
      ge       = trial >= {1'b0, total_ff};
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      idx_in         = idx_ff;
      weight_in      = weight_ff;
      total_in       = total_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      use_weights_in = csr_we ? csr_wdata : use_weights_ff;
      strobe_in      = 1'b0;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = bin_sat;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            total_in  = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_BIN) begin
               clr_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               idx_in    = flat_idx;
               weight_in = weight_eff;
               unique case (req_data.opcode)
                  wch_pkg::OP_CLEAR: state_in = S_CLEAR;
                  wch_pkg::OP_ACCUM: state_in = S_ACC_RD;
                  wch_pkg::OP_QUERY: state_in = S_Q_RD;
                  default:           state_in = S_IDLE;
               endcase
            end
         end
         S_ACC_RD: begin
            state_in = S_ACC_UPD;
         end
         S_ACC_UPD: begin
            mem_we   = 1'b1;
            total_in = tot_sat;
            state_in = S_IDLE;
         end
         S_Q_RD: begin
            state_in = S_Q_LD;
         end
         S_Q_LD: begin
            if (total_ff == '0) begin
               rsp_in.bin_share  = '0;
               rsp_in.total_zero = 1'b1;
               strobe_in         = 1'b1;
               state_in          = S_IDLE;
            end else begin
               rem_in   = {1'b0, num_clip};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = S_Q_DIV;
            end
         end
         S_Q_DIV: begin
            rem_in = ge ? (trial - {1'b0, total_ff}) : trial;
            quo_in = {quo_ff[SW-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               rsp_in.bin_share  = {quo_ff[SW-2:0], ge};
               rsp_in.total_zero = 1'b0;
               strobe_in         = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         total_ff       <= '0;
         use_weights_ff <= 1'b1;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         total_ff       <= total_in;
         use_weights_ff <= use_weights_in;
         strobe_ff      <= strobe_in;
      end
      idx_ff    <= idx_in;
      weight_ff <= weight_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[idx_ff];
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || state_ff == S_IDLE))
      else $error("accept did not leave idle correctly");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer still busy");

   a_zero_share: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.total_zero) |-> (rsp_data.bin_share == '0))
      else $error("empty histogram returned nonzero share");

   a_share_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.bin_share <= wch_pkg::ONE_Q16))
      else $error("share above one");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_DIV && cnt_ff != '0) |-> (rem_ff < {1'b0, total_ff}))
      else $error("divider remainder not below divisor");

endmodule

### tb/sv/tb.sv
module tb;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         NUM_BINS      = 4096;
   localparam int         SETTLE_CYCLES = 24;
   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         PHASE_ITEMS   = 195;
   localparam int         IDLE_PCT      = 38;

   typedef struct {
      wch_pkg::req_type beat;
      bit               fixed;
      wch_pkg::rsp_type want;
   } dir_row_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             start      = 1'b0;
   logic             csr_we     = 1'b0;
   logic             csr_wdata  = 1'b0;
   wch_pkg::req_type req_data   = '0;
   logic             busy;
   logic             rsp_strobe;
   wch_pkg::rsp_type rsp_data;

   // shadow histogram
   logic [39:0] hist_bin [NUM_BINS];
   logic [39:0] hist_total;
   bit          weights_on;

   wch_pkg::rsp_type pending_shares [$];
   dir_row_type      dir_rows [$];
   logic [23:0]      palette [8];

   int errors       = 0;
   int cycle_count  = 0;
   int clears_left  = 6;
   int n_accum      = 0;
   int n_query      = 0;
   int n_clear      = 0;
   int n_unused     = 0;
   int n_empty_rsp  = 0;
   int n_full_rsp   = 0;
   int n_rsp        = 0;

   weighted_color_histogram u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("weighted_color_histogram: mismatch");
         $finish;
      end
   end

   function automatic logic [39:0] sat_sum(logic [39:0] x, logic [16:0] y);
      logic [40:0] s;
      s = {1'b0, x} + {24'b0, y};
      return s[40] ? '1 : s[39:0];
   endfunction

   function automatic int unsigned bin_of(wch_pkg::req_type b);
      return 32'({b.chan_a[7:4], b.chan_b[7:4], b.chan_c[7:4]});
   endfunction

   task automatic hist_update(input wch_pkg::req_type b, output bit has_rsp,
                              output wch_pkg::rsp_type p);
      logic [16:0] amount;
      logic [39:0] n;
      logic [63:0] q;
      int unsigned idx;
      has_rsp = 1'b0;
      p = '0;
      idx = bin_of(b);
      case (b.opcode)
         wch_pkg::OP_CLEAR: begin
            foreach (hist_bin[i]) hist_bin[i] = '0;
            hist_total = '0;
         end
         wch_pkg::OP_ACCUM: begin
            amount = wch_pkg::ONE_Q16;
            if (weights_on && b.pixel_weight < wch_pkg::ONE_Q16) amount = b.pixel_weight;
            hist_bin[idx] = sat_sum(hist_bin[idx], amount);
            hist_total    = sat_sum(hist_total, amount);
         end
         wch_pkg::OP_QUERY: begin
            has_rsp = 1'b1;
            if (hist_total == 0) begin
               p.total_zero = 1'b1;
            end else begin
               n = (hist_bin[idx] > hist_total) ? hist_total : hist_bin[idx];
               q = ({24'b0, n} << 16) / {24'b0, hist_total};
               p.bin_share = q[16:0];
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      wch_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         n_rsp++;
         if (pending_shares.size() == 0) begin
            $error("unexpected result beat: bin_share=%0d total_zero=%0d",
                   rsp_data.bin_share, rsp_data.total_zero);
            errors++;
         end else begin
            want = pending_shares.pop_front();
            if (rsp_data.bin_share !== want.bin_share) begin
               $error("bin_share: expected %0d, got %0d", want.bin_share, rsp_data.bin_share);
               errors++;
            end
            if (rsp_data.total_zero !== want.total_zero) begin
               $error("total_zero: expected %0d, got %0d", want.total_zero,
                      rsp_data.total_zero);
               errors++;
            end
            if (want.total_zero) n_empty_rsp++;
            if (want.bin_share == wch_pkg::ONE_Q16) n_full_rsp++;
         end
      end
   end

   task automatic send_beat(input wch_pkg::req_type b, input bit fixed,
                            input wch_pkg::rsp_type fixed_want);
      bit               has_rsp;
      wch_pkg::rsp_type p;
      start    <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (busy);
      hist_update(b, has_rsp, p);
      if (has_rsp) pending_shares.push_back(fixed ? fixed_want : p);
      case (b.opcode)
         wch_pkg::OP_CLEAR: n_clear++;
         wch_pkg::OP_ACCUM: n_accum++;
         wch_pkg::OP_QUERY: n_query++;
         default:           n_unused++;
      endcase
   endtask

   task automatic idle_gap();
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clock);
   endtask

   // hold off until every result is back and the block has gone quiet
   task automatic drain_results();
      start <= 1'b0;
      while (pending_shares.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_weights(input bit v);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      weights_on = v;
      csr_we    <= 1'b0;
   endtask

   task automatic refresh_palette();
      foreach (palette[i]) palette[i] = 24'($urandom);
   endtask

   task automatic pick_beat(output wch_pkg::req_type b);
      int unsigned sel, k;
      logic [23:0] px;
      sel = $urandom_range(99);
      if (sel < 1 && clears_left > 0) begin
         b.opcode = wch_pkg::OP_CLEAR;
         clears_left--;
      end else if (sel < 5) begin
         b.opcode = OP_UNUSED;
      end else if (sel < 60) begin
         b.opcode = wch_pkg::OP_ACCUM;
      end else begin
         b.opcode = wch_pkg::OP_QUERY;
      end
      if ($urandom_range(3) != 0) begin
         px = palette[$urandom_range(7)];
         px[19:16] = 4'($urandom);
         px[11:8]  = 4'($urandom);
         px[3:0]   = 4'($urandom);
      end else begin
         px = 24'($urandom);
      end
      {b.chan_a, b.chan_b, b.chan_c} = px;
      k = $urandom_range(9);
      case (k)
         0:       b.pixel_weight = '0;
         1:       b.pixel_weight = wch_pkg::ONE_Q16;
         2:       b.pixel_weight = 17'($urandom_range(131071));
         3:       b.pixel_weight = 17'($urandom_range(255));
         default: b.pixel_weight = 17'($urandom_range(65536));
      endcase
   endtask

   task automatic add_row(input logic [1:0] op, input int a, input int b, input int c,
                          input int w, input bit fixed, input int share, input bit zf);
      dir_row_type r;
      r.beat.opcode       = op;
      r.beat.chan_a       = 8'(a);
      r.beat.chan_b       = 8'(b);
      r.beat.chan_c       = 8'(c);
      r.beat.pixel_weight = 17'(w);
      r.fixed             = fixed;
      r.want.bin_share    = 17'(share);
      r.want.total_zero   = zf;
      dir_rows.push_back(r);
   endtask

   task automatic random_phase(input int items, input bit quiet_stretch);
      wch_pkg::req_type b;
      int               counted;
      counted = 0;
      while (counted < items) begin
         if (!(quiet_stretch && counted >= 40 && counted < 140) &&
             $urandom_range(99) < IDLE_PCT)
            idle_gap();
         if (quiet_stretch && counted == 150) drain_results();
         pick_beat(b);
         send_beat(b, 1'b0, '0);
         if (b.opcode == wch_pkg::OP_CLEAR) refresh_palette();
         if (b.opcode != OP_UNUSED) counted++;
      end
   endtask

   initial begin
      foreach (hist_bin[i]) hist_bin[i] = '0;
      hist_total = '0;
      weights_on = 1'b1;
      refresh_palette();

      //      op                  a    b    c    weight  fixed share  zf
      add_row(wch_pkg::OP_QUERY,    0,   0,   0,       0, 1,      0, 1);
      add_row(wch_pkg::OP_ACCUM,    0,   0,   0,   65536, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,    0,   0,   0,       0, 1,  65536, 0);
      add_row(wch_pkg::OP_ACCUM,  255, 255, 255, 131071, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,  255, 255, 255,       0, 1,  32768, 0);
      add_row(wch_pkg::OP_QUERY,   15,  15,  15,       0, 1,  32768, 0);
      add_row(wch_pkg::OP_QUERY,   16,   0,   0,       0, 1,      0, 0);
      add_row(wch_pkg::OP_ACCUM,  128,  64, 200,       0, 0,      0, 0);
      add_row(wch_pkg::OP_ACCUM,  255,   0, 255,       1, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,  255,   0, 255,       0, 0,      0, 0);
      add_row(wch_pkg::OP_ACCUM,    0, 255,   0,   65537, 0,      0, 0);
      add_row(OP_UNUSED,           99,  99,  99,   65536, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,    0, 255,   0,       0, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,  128,  64, 200,  131071, 0,      0, 0);
      add_row(wch_pkg::OP_CLEAR,  255, 255, 255, 131071, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,    0,   0,   0,       0, 1,      0, 1);
      add_row(OP_UNUSED,          255, 255, 255, 131071, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,  255, 255, 255,       0, 1,      0, 1);
      add_row(wch_pkg::OP_ACCUM,   17,  34,  51,   12345, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,   17,  34,  51,       0, 1,  65536, 0);
      add_row(wch_pkg::OP_ACCUM,  100, 100, 100,   43690, 0,      0, 0);
      add_row(wch_pkg::OP_ACCUM,  170,  85, 240,   21845, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,  100, 100, 100,       0, 0,      0, 0);
      add_row(wch_pkg::OP_QUERY,  170,  85, 240,       0, 0,      0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if ($urandom_range(99) < IDLE_PCT) idle_gap();
         send_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].want);
      end

      set_weights(1'b0);
      random_phase(PHASE_ITEMS, 1'b1);
      set_weights(1'b1);
      random_phase(PHASE_ITEMS, 1'b0);
      set_weights(1'b0);
      random_phase(PHASE_ITEMS, 1'b0);

      drain_results();
      $display("covered %0d accumulates, %0d queries, %0d clears, %0d unused-opcode beats",
               n_accum, n_query, n_clear, n_unused);
      $display("%0d results checked (%0d empty-histogram, %0d full-share), weights on and off",
               n_rsp, n_empty_rsp, n_full_rsp);
      if (errors == 0) begin
         $display("weighted_color_histogram: match");
      end else begin
         $display("weighted_color_histogram: mismatch");
      end
      $finish;
   end

endmodule
